@@ rtl/core/sorted_table_binary_search_top_macros.svh @@
// Assertion macros shared by the sorted key table search block.
`ifndef SORTED_TABLE_BINARY_SEARCH_TOP_MACROS_SVH
`define SORTED_TABLE_BINARY_SEARCH_TOP_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define STBS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define STBS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/stbs_pkg.sv @@
// Types, codes and the control program of the sorted key table search block.
package stbs_pkg;

  // Operation codes of an input item.
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_CEIL  = 2'd1,
    OP_EXACT = 2'd2,
    OP_FLOOR = 2'd3
  } op_t;

  // Configuration register index, taken from byte address bit 2.
  localparam logic CFG_ENTRY_COUNT = 1'b0;

  localparam int KEY_W   = 64;
  localparam int INDEX_W = 10;
  localparam int COUNT_W = 11;

  typedef struct packed {
    logic [1:0]         operation;
    logic [INDEX_W-1:0] entry_index;
    logic [KEY_W-1:0]   key;
  } stbs_in_t;

  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] position;
  } stbs_out_t;

  // Sequencer program.
  localparam int PC_W = 1;
  localparam logic [PC_W-1:0] PC_IDLE = 1'b0;
  localparam logic [PC_W-1:0] PC_STEP = 1'b1;

  typedef enum logic {
    BR_DISPATCH = 1'b0,  // stay unless a search starts, then go on
    BR_WHILE    = 1'b1   // stay while the search goes on, else jump
  } br_t;

  typedef struct packed {
    logic            accept_en;
    logic            step_en;
    br_t             br;
    logic [PC_W-1:0] target;
  } prog_word_t;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    logic accept;
    logic step_en;
  } ctl_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic more;
  } dp_stat_t;

  function automatic prog_word_t prog_word(input logic [PC_W-1:0] pc);
    prog_word_t w;
    unique case (pc)
      PC_IDLE: w = '{accept_en: 1'b1, step_en: 1'b0, br: BR_DISPATCH, target: PC_IDLE};
      PC_STEP: w = '{accept_en: 1'b0, step_en: 1'b1, br: BR_WHILE,    target: PC_IDLE};
      default: w = '{accept_en: 1'b1, step_en: 1'b0, br: BR_DISPATCH, target: PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

@@ rtl/core/stbs_ram.sv @@
// Generic single-port RAM with registered read data.
module stbs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/stbs_seq.sv @@
// Microcoded sequencer: step counter, program table and branch logic.
module stbs_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              is_search,
  input  stbs_pkg::dp_stat_t stat,
  output stbs_pkg::ctl_t     ctl,
  output logic              busy
);
  import stbs_pkg::*;

  logic [PC_W-1:0] pc_r;
  logic [PC_W-1:0] pc_nxt;
  prog_word_t      word;

  assign word = prog_word(pc_r);

  always_comb begin
    unique case (word.br)
      BR_DISPATCH: pc_nxt = (start && is_search) ? PC_W'(pc_r + 1'b1) : pc_r;
      BR_WHILE:    pc_nxt = stat.more ? pc_r : word.target;
      default:     pc_nxt = PC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign busy        = !word.accept_en;
  assign ctl.accept  = word.accept_en && start;
  assign ctl.step_en = word.step_en;

endmodule

@@ rtl/core/stbs_dp.sv @@
// Search datapath: key table, search bounds, compare and result register.
module stbs_dp #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  stbs_pkg::ctl_t                  ctl,
  input  stbs_pkg::stbs_in_t              in_item,
  input  logic [stbs_pkg::COUNT_W-1:0]    entry_count,
  output stbs_pkg::dp_stat_t              stat,
  output logic                            out_valid,
  output stbs_pkg::stbs_out_t             out_result
);
  import stbs_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  op_t              op_r;
  logic [KEY_W-1:0] key_r;
  logic [CW-1:0]    low_r, low_nxt;
  logic [CW-1:0]    hi_r, hi_nxt;
  logic [AW-1:0]    mid_r;
  logic [CW-1:0]    mid_nxt, mid_ext, width_m1;
  logic             found_r, found_nxt;
  logic [AW-1:0]    pos_r, pos_nxt;
  logic             exact_hit;
  logic             out_valid_r;
  stbs_out_t        out_r;

  logic             is_load, load_we, search_go, live, more, emit;
  logic [CW-1:0]    span;
  logic [AW-1:0]    ram_addr;
  logic [KEY_W-1:0] rd_key;

  assign is_load   = (in_item.operation == OP_LOAD);
  assign search_go = ctl.accept && !is_load;
  assign load_we   = ctl.accept && is_load &&
                     (32'(in_item.entry_index) < 32'(TABLE_DEPTH));
  assign span      = (32'(entry_count) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                          : CW'(entry_count);
  assign live      = (low_r < hi_r);
  assign mid_ext   = CW'(mid_r);

  // Bounds are kept as [low, hi) so that the empty range needs no sign.
  always_comb begin
    low_nxt   = low_r;
    hi_nxt    = hi_r;
    found_nxt = found_r;
    pos_nxt   = pos_r;
    exact_hit = 1'b0;
    if (search_go) begin
      low_nxt   = '0;
      hi_nxt    = span;
      found_nxt = 1'b0;
      pos_nxt   = '0;
    end else if (ctl.step_en && live) begin
      unique case (op_r)
        OP_CEIL: begin
          if (rd_key >= key_r) begin
            found_nxt = 1'b1;
            pos_nxt   = mid_r;
            hi_nxt    = mid_ext;
          end else begin
            low_nxt = mid_ext + CW'(1);
          end
        end
        OP_EXACT: begin
          if (rd_key == key_r) begin
            found_nxt = 1'b1;
            pos_nxt   = mid_r;
            exact_hit = 1'b1;
          end else if (rd_key < key_r) begin
            low_nxt = mid_ext + CW'(1);
          end else begin
            hi_nxt = mid_ext;
          end
        end
        OP_FLOOR: begin
          if (rd_key <= key_r) begin
            found_nxt = 1'b1;
            pos_nxt   = mid_r;
            low_nxt   = mid_ext + CW'(1);
          end else begin
            hi_nxt = mid_ext;
          end
        end
        default: begin
          low_nxt = low_r;
        end
      endcase
    end
  end

  // Midpoint of the next range; it is only used while that range is live.
  assign width_m1 = hi_nxt - low_nxt - CW'(1);
  assign mid_nxt  = low_nxt + (width_m1 >> 1);

  assign more = ctl.step_en && live && !exact_hit && (low_nxt < hi_nxt);
  assign emit = ctl.step_en && !more;

  assign ram_addr = (ctl.accept && is_load) ? AW'(in_item.entry_index) : AW'(mid_nxt);

  stbs_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_key_table (
    .clk   (clk),
    .we    (load_we),
    .addr  (ram_addr),
    .wdata (in_item.key),
    .rdata (rd_key)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= emit;
    end
    if (search_go) begin
      op_r  <= op_t'(in_item.operation);
      key_r <= in_item.key;
    end
    low_r   <= low_nxt;
    hi_r    <= hi_nxt;
    mid_r   <= AW'(mid_nxt);
    found_r <= found_nxt;
    pos_r   <= pos_nxt;
    if (emit) begin
      out_r.found    <= found_nxt;
      out_r.position <= found_nxt ? INDEX_W'(pos_nxt) : '0;
    end
  end

  assign stat.more  = more;
  assign out_valid  = out_valid_r;
  assign out_result = out_r;

endmodule

@@ rtl/core/sorted_table_binary_search_top.sv @@
// Top level of the sorted key table search block with its register port.
//
// The block holds a table of TABLE_DEPTH 64-bit keys that load items write
// in ascending order, and answers ceiling, exact and floor searches over the
// first entry_count entries. An item is taken at a rising edge where start
// is high and busy is low. A load item writes its entry at that edge, gives
// no result and leaves busy low, so loads can follow each other every cycle.
// A search item keeps busy high while it makes k compare steps, where k
// is at most floor(log2(n)) + 1 for n searched entries (11 for a full
// 1024-entry table) and exactly 1 for an empty table, whose single step
// makes no compare; an exact search stops at its first hit. Each compare
// needs one read of the single-port key table, so the block takes no new
// item until the last step of a search is done. The result appears for
// exactly one cycle with out_valid, in the first cycle in which busy is
// low again; the receiver cannot stall it, so it must take every result
// as it comes. Table entries are not cleared at reset: a search that reads
// an entry inside entry_count which was never loaded returns an undefined
// answer.
module sorted_table_binary_search_top #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Item channel.
  input  logic                 start,
  output logic                 busy,
  input  stbs_pkg::stbs_in_t   in_item,
  // Result channel.
  output logic                 out_valid,
  output stbs_pkg::stbs_out_t  out_result,
  // Register port; entry_count lies at byte address 0.
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import stbs_pkg::*;

`include "sorted_table_binary_search_top_macros.svh"

  logic [COUNT_W-1:0] entry_count_r;
  ctl_t               ctl;
  dp_stat_t           stat;
  logic               is_search;
  logic               take_search;
  logic               take_load;

  // The count register is written at the access phase of an APB write.
  // Addresses beyond the single register are accepted and ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
    end else if (psel && penable && pwrite && (paddr[2] == CFG_ENTRY_COUNT)) begin
      entry_count_r <= pwdata[COUNT_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == CFG_ENTRY_COUNT) ? 32'(entry_count_r) : '0;

  assign is_search = (in_item.operation != OP_LOAD);

  // The sequencer steps through a two-word program: an idle word that takes
  // items, and a compare word that repeats once per halving step.
  stbs_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .is_search (is_search),
    .stat      (stat),
    .ctl       (ctl),
    .busy      (busy)
  );

  // The datapath owns the key table, the search bounds and the result.
  stbs_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .in_item     (in_item),
    .entry_count (entry_count_r),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_result  (out_result)
  );

  assign take_search = start && !busy && is_search;
  assign take_load   = start && !busy && !is_search;

  // A search item always raises busy in the cycle after it is taken.
  `STBS_ASSERT_NEXT(a_search_busy, take_search, busy, "search item did not raise busy")
  // A load item neither blocks the next item nor produces a result.
  `STBS_ASSERT_NEXT(a_load_silent, take_load, !busy && !out_valid, "load item stalled")
  // Results are single-cycle strobes.
  `STBS_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid, "result strobe too long")
  // A result only shows up right after a search step ended.
  `STBS_ASSERT_NOW(a_result_after_search, out_valid, !busy && $past(busy), "result without search")

endmodule
